[hw/rtl/htw_pkg.sv]
// Package for the Huffman tree-walk decoder: capacities, derived widths,
// step codes, the in_item_t shared by the front queue and bit engine, and result_t.
// No dependencies.
`timescale 1ns / 1ps

package htw_pkg;

  localparam int NODE_CAPACITY  = 511;
  localparam int STACK_CAPACITY = 256;

  localparam int SYM_W         = 8;
  localparam int COUNT_W       = 32;
  localparam int BITS_PER_BYTE = 8;

  localparam int NODE_IDX_W  = $clog2(NODE_CAPACITY);
  localparam int NODE_CNT_W  = $clog2(NODE_CAPACITY + 1);
  localparam int STACK_IDX_W = $clog2(STACK_CAPACITY);
  localparam int STACK_TOP_W = $clog2(STACK_CAPACITY + 1);
  localparam int BIT_IDX_W   = $clog2(BITS_PER_BYTE);
  localparam int SYM_CNT_W   = $clog2(SYM_W + 1);

  localparam logic [NODE_CNT_W-1:0]  NODE_LIMIT  = NODE_CNT_W'(NODE_CAPACITY);
  localparam logic [STACK_TOP_W-1:0] STACK_LIMIT = STACK_TOP_W'(STACK_CAPACITY);
  localparam logic [SYM_CNT_W-1:0]   SYM_DONE    = SYM_CNT_W'(SYM_W);
  localparam logic [BIT_IDX_W-1:0]   LAST_BIT    = BIT_IDX_W'(BITS_PER_BYTE - 1);

  // Per byte the engine runs one step per code bit, then a resolve step for
  // the read issued by the last bit, then a flush step for the held result.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] RESOLVE_STEP = STEP_W'(BITS_PER_BYTE);
  localparam logic [STEP_W-1:0] FLUSH_STEP   = STEP_W'(BITS_PER_BYTE + 1);

  typedef struct packed {
    logic [SYM_W-1:0] compressed_byte;
    logic             final_byte;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_symbol;
    logic             tree_error;
  } result_t;

endpackage

[hw/rtl/htw_in_if.sv]
// Input channel interface of the Huffman tree-walk decoder: valid/ready and one
// compressed byte with its end-of-block mark. Depends on htw_pkg.
`timescale 1ns / 1ps

interface htw_in_if;
  logic                     valid;
  logic                     ready;
  logic [htw_pkg::SYM_W-1:0] compressed_byte;
  logic                     final_byte;

  modport source (output valid, output compressed_byte, output final_byte, input ready);
  modport sink   (input valid, input compressed_byte, input final_byte, output ready);
endinterface

[hw/rtl/htw_out_if.sv]
// Result channel interface of the Huffman tree-walk decoder: valid/ready and one
// decoded symbol with its flags. Depends on htw_pkg.
`timescale 1ns / 1ps

interface htw_out_if;
  logic                     valid;
  logic                     ready;
  logic [htw_pkg::SYM_W-1:0] symbol;
  logic                     last_symbol;
  logic                     tree_error;

  modport source (output valid, output symbol, output last_symbol, output tree_error,
                  input ready);
  modport sink   (input valid, input symbol, input last_symbol, input tree_error,
                  output ready);
endinterface

[hw/rtl/huffman_tree_walk_decoder_unit.sv]
// Top level of the Huffman tree-walk decoder: symbol count register, front byte
// queue and bit engine. Depends on htw_pkg, htw_in_if, htw_out_if, htw_front, htw_back.
// Usage:
// Each input transaction carries one compressed byte, read most significant bit
// first, and a final_byte mark that closes the block. The first bits of a block
// are a preorder tree header (0 = internal node, 1 = leaf plus 8 symbol bits); the
// bits after it are code bits, each leaf reached gives one result transaction.
// A header that overflows the node table or the stack gives a single result with
// tree_error set. The last result caused by a byte carries last_symbol.
// cfg_we/cfg_wdata write the number of symbols expected per block; write it only
// while the block is idle.
// Each byte takes one step per code bit through the node table read port, then
// a step to settle the table read issued by the last bit and a step to flush the
// held result. A result waits for the byte's next result or for the flush step.
// A two-entry queue accepts bytes while the engine works; when the result receiver
// stalls, the engine holds its current step until the output register frees up.
// Reset clears the run state and the symbol count; the node table and stack need
// no clearing, since a header writes every entry before it is read.
`timescale 1ns / 1ps

module huffman_tree_walk_decoder_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  htw_in_if.sink                      in_chan,
  htw_out_if.source                   out_chan,
  input  logic                        cfg_we,
  input  logic [htw_pkg::COUNT_W-1:0] cfg_wdata
);

  logic [htw_pkg::COUNT_W-1:0] symbol_count_r;
  logic                        head_valid;
  htw_pkg::in_item_t           head;
  logic                        head_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      symbol_count_r <= '0;
    end else if (cfg_we) begin
      symbol_count_r <= cfg_wdata;
    end
  end

  htw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  htw_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head         (head),
    .head_pop     (head_pop),
    .symbol_count (symbol_count_r),
    .out_chan     (out_chan)
  );

endmodule

[hw/rtl/htw_front.sv]
// Front end of the decoder: accepts input transactions into a two-entry byte queue
// and presents the oldest byte to the bit engine. Depends on htw_pkg, htw_in_if.
`timescale 1ns / 1ps

module htw_front (
  input  logic              clk,
  input  logic              rst_n,
  htw_in_if.sink            in_chan,
  output logic              head_valid,
  output htw_pkg::in_item_t head,
  input  logic              head_pop
);

  htw_pkg::in_item_t ent_r [0:1];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        fill_r, fill_nxt;
  logic              push;
  logic              pop;

  assign in_chan.ready = (fill_r != 2'd2);
  assign push          = in_chan.valid && in_chan.ready;
  assign head_valid    = (fill_r != 2'd0);
  assign pop           = head_pop && head_valid;
  assign head          = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r].compressed_byte <= in_chan.compressed_byte;
      ent_r[wr_ptr_r].final_byte      <= in_chan.final_byte;
    end
  end

endmodule

[hw/rtl/htw_back.sv]
// Bit engine of the decoder: rebuilds the code tree from the header, walks it one
// code bit per step and drives the result register. Holds the node table and the
// pending-node stack. Depends on htw_pkg, htw_out_if.
`timescale 1ns / 1ps

module htw_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  htw_pkg::in_item_t             head,
  output logic                          head_pop,
  input  logic [htw_pkg::COUNT_W-1:0]   symbol_count,
  htw_out_if.source                     out_chan
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DECODE = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  localparam int IW = htw_pkg::NODE_IDX_W;
  localparam int SW = htw_pkg::SYM_W;

  // Node table split by field so that each part has one write per step.
  logic [SW:0]   leaf_mem [0:htw_pkg::NODE_CAPACITY-1];
  logic [IW-1:0] a_mem    [0:htw_pkg::NODE_CAPACITY-1];
  logic [IW-1:0] b_mem    [0:htw_pkg::NODE_CAPACITY-1];
  logic [IW-1:0] stk_mem  [0:htw_pkg::STACK_CAPACITY-1];

  logic [htw_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic [1:0]                      phase_r, phase_nxt;
  logic [htw_pkg::STACK_TOP_W-1:0] stack_top_r, stack_top_nxt;
  logic [htw_pkg::NODE_CNT_W-1:0]  nfn_r, nfn_nxt;
  logic [IW-1:0]                   cur_r, cur_nxt;
  logic                            cur_stk_r, cur_stk_nxt;
  logic                            attach_b_r, attach_b_nxt;
  logic [SW-1:0]                   shift_r, shift_nxt;
  logic [htw_pkg::SYM_CNT_W-1:0]   sym_cnt_r, sym_cnt_nxt;
  logic [htw_pkg::COUNT_W-1:0]     emitted_r, emitted_nxt;
  logic                            pend_r, pend_nxt;
  logic                            root_leaf_r, root_leaf_nxt;
  logic [SW-1:0]                   root_sym_r, root_sym_nxt;
  logic [IW-1:0]                   root_a_r, root_a_nxt;
  logic [IW-1:0]                   root_b_r, root_b_nxt;

  logic                            hold_valid_r;
  htw_pkg::result_t                hold_r;
  logic                            out_valid_r;
  htw_pkg::result_t                out_res_r;

  logic                            rd_leaf_r;
  logic [SW-1:0]                   rd_sym_r;
  logic [IW-1:0]                   rd_a_r;
  logic [IW-1:0]                   rd_b_r;
  logic [IW-1:0]                   stk_q_r;

  logic [IW-1:0]                   cur_eff;
  logic [htw_pkg::BIT_IDX_W-1:0]   bit_sel;
  logic                            bit_val;
  logic                            count_hit;
  logic [htw_pkg::COUNT_W-1:0]     emitted_inc;
  logic [htw_pkg::STACK_TOP_W-1:0] stack_dec;

  logic                            new_vld;
  logic [SW-1:0]                   new_sym;
  logic                            new_err;
  logic                            push_req;
  htw_pkg::result_t                push_res;
  logic                            can_push;
  logic                            advance;

  logic                            leaf_we;
  logic [IW-1:0]                   leaf_waddr;
  logic [SW:0]                     leaf_wdata;
  logic                            a_we;
  logic                            b_we;
  logic [IW-1:0]                   ab_waddr;
  logic [IW-1:0]                   ab_wdata;
  logic                            stk_we;
  logic                            stk_re;
  logic [htw_pkg::STACK_IDX_W-1:0] stk_raddr;
  logic                            rd_en;
  logic [IW-1:0]                   rd_addr;

  assign cur_eff     = cur_stk_r ? stk_q_r : cur_r;
  assign bit_sel     = htw_pkg::LAST_BIT - step_r[htw_pkg::BIT_IDX_W-1:0];
  assign bit_val     = head.compressed_byte[bit_sel];
  assign emitted_inc = emitted_r + 1'b1;
  assign count_hit   = (emitted_inc == symbol_count);
  assign stack_dec   = stack_top_r - 1'b1;
  assign stk_raddr   = stack_dec[htw_pkg::STACK_IDX_W-1:0];

  always_comb begin
    phase_nxt     = phase_r;
    stack_top_nxt = stack_top_r;
    nfn_nxt       = nfn_r;
    cur_nxt       = cur_r;
    cur_stk_nxt   = cur_stk_r;
    attach_b_nxt  = attach_b_r;
    shift_nxt     = shift_r;
    sym_cnt_nxt   = sym_cnt_r;
    emitted_nxt   = emitted_r;
    pend_nxt      = pend_r;
    root_leaf_nxt = root_leaf_r;
    root_sym_nxt  = root_sym_r;
    root_a_nxt    = root_a_r;
    root_b_nxt    = root_b_r;
    new_vld       = 1'b0;
    new_sym       = '0;
    new_err       = 1'b0;
    leaf_we       = 1'b0;
    leaf_waddr    = nfn_r[IW-1:0];
    leaf_wdata    = '0;
    a_we          = 1'b0;
    b_we          = 1'b0;
    ab_waddr      = cur_eff;
    ab_wdata      = nfn_r[IW-1:0];
    stk_we        = 1'b0;
    stk_re        = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = bit_val ? root_b_r : root_a_r;

    if (step_r < htw_pkg::RESOLVE_STEP) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (sym_cnt_r == '0) begin
            if (nfn_r >= htw_pkg::NODE_LIMIT ||
                (!bit_val && stack_top_r >= htw_pkg::STACK_LIMIT)) begin
              phase_nxt = PH_DONE;
              new_vld   = 1'b1;
              new_err   = 1'b1;
            end else begin
              // Hook the new node under the attach point: child A for a
              // fresh internal node, child B for one taken off the stack.
              if (nfn_r != '0) begin
                if (attach_b_r) begin
                  b_we = 1'b1;
                  if (cur_eff == '0) begin
                    root_b_nxt = nfn_r[IW-1:0];
                  end
                end else begin
                  a_we = 1'b1;
                  if (cur_eff == '0) begin
                    root_a_nxt = nfn_r[IW-1:0];
                  end
                end
              end
              nfn_nxt     = nfn_r + 1'b1;
              leaf_we     = 1'b1;
              leaf_wdata  = {bit_val, {SW{1'b0}}};
              cur_nxt     = nfn_r[IW-1:0];
              cur_stk_nxt = 1'b0;
              if (nfn_r == '0) begin
                root_leaf_nxt = bit_val;
              end
              if (bit_val) begin
                shift_nxt   = '0;
                sym_cnt_nxt = htw_pkg::SYM_CNT_W'(1);
              end else begin
                stk_we        = 1'b1;
                stack_top_nxt = stack_top_r + 1'b1;
                attach_b_nxt  = 1'b0;
              end
            end
          end else begin
            shift_nxt = {shift_r[SW-2:0], bit_val};
            if (sym_cnt_r == htw_pkg::SYM_DONE) begin
              leaf_we     = 1'b1;
              leaf_waddr  = cur_eff;
              leaf_wdata  = {1'b1, shift_nxt};
              sym_cnt_nxt = '0;
              if (cur_eff == '0) begin
                root_sym_nxt = shift_nxt;
              end
              if (stack_top_r == '0) begin
                phase_nxt = (symbol_count == '0) ? PH_DONE : PH_DECODE;
                pend_nxt  = 1'b0;
              end else begin
                stack_top_nxt = stack_dec;
                stk_re        = 1'b1;
                cur_stk_nxt   = 1'b1;
                attach_b_nxt  = 1'b1;
              end
            end else begin
              sym_cnt_nxt = sym_cnt_r + 1'b1;
            end
          end
        end
        PH_DECODE: begin
          if (root_leaf_r) begin
            new_vld     = 1'b1;
            new_sym     = root_sym_r;
            emitted_nxt = emitted_inc;
            if (count_hit) begin
              phase_nxt = PH_DONE;
            end
          end else if (pend_r && rd_leaf_r) begin
            // The previous bit landed on a leaf; this bit starts at the root.
            new_vld     = 1'b1;
            new_sym     = rd_sym_r;
            emitted_nxt = emitted_inc;
            if (count_hit) begin
              phase_nxt = PH_DONE;
              pend_nxt  = 1'b0;
            end else begin
              rd_en    = 1'b1;
              pend_nxt = 1'b1;
            end
          end else begin
            rd_en    = 1'b1;
            pend_nxt = 1'b1;
            if (pend_r) begin
              rd_addr = bit_val ? rd_b_r : rd_a_r;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (step_r == htw_pkg::RESOLVE_STEP) begin
      if (phase_r == PH_DECODE && pend_r && rd_leaf_r && !root_leaf_r) begin
        new_vld     = 1'b1;
        new_sym     = rd_sym_r;
        emitted_nxt = emitted_inc;
        pend_nxt    = 1'b0;
        if (count_hit) begin
          phase_nxt = PH_DONE;
        end
      end
    end else if (head.final_byte) begin
      phase_nxt     = PH_HEADER;
      stack_top_nxt = '0;
      nfn_nxt       = '0;
      cur_nxt       = '0;
      cur_stk_nxt   = 1'b0;
      attach_b_nxt  = 1'b0;
      shift_nxt     = '0;
      sym_cnt_nxt   = '0;
      emitted_nxt   = '0;
      pend_nxt      = 1'b0;
    end
  end

  // A result waits in the hold register until the next one shows up, so the
  // last result of a byte can carry its mark when the byte is flushed.
  always_comb begin
    push_res.symbol     = hold_r.symbol;
    push_res.tree_error = hold_r.tree_error;
    if (step_r == htw_pkg::FLUSH_STEP) begin
      push_req             = hold_valid_r;
      push_res.last_symbol = 1'b1;
    end else begin
      push_req             = hold_valid_r && new_vld;
      push_res.last_symbol = 1'b0;
    end
  end

  assign can_push = !out_valid_r || out_chan.ready;
  assign advance  = head_valid && (!push_req || can_push);
  assign head_pop = advance && (step_r == htw_pkg::FLUSH_STEP);

  always_comb begin
    step_nxt = (step_r == htw_pkg::FLUSH_STEP) ? '0 : step_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= '0;
      phase_r      <= PH_HEADER;
      stack_top_r  <= '0;
      nfn_r        <= '0;
      cur_r        <= '0;
      cur_stk_r    <= 1'b0;
      attach_b_r   <= 1'b0;
      shift_r      <= '0;
      sym_cnt_r    <= '0;
      emitted_r    <= '0;
      pend_r       <= 1'b0;
      hold_valid_r <= 1'b0;
    end else if (advance) begin
      step_r      <= step_nxt;
      phase_r     <= phase_nxt;
      stack_top_r <= stack_top_nxt;
      nfn_r       <= nfn_nxt;
      cur_r       <= cur_nxt;
      cur_stk_r   <= cur_stk_nxt;
      attach_b_r  <= attach_b_nxt;
      shift_r     <= shift_nxt;
      sym_cnt_r   <= sym_cnt_nxt;
      emitted_r   <= emitted_nxt;
      pend_r      <= pend_nxt;
      if (step_r == htw_pkg::FLUSH_STEP) begin
        hold_valid_r <= 1'b0;
      end else if (new_vld) begin
        hold_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      root_leaf_r <= root_leaf_nxt;
      root_sym_r  <= root_sym_nxt;
      root_a_r    <= root_a_nxt;
      root_b_r    <= root_b_nxt;
      if (step_r != htw_pkg::FLUSH_STEP && new_vld) begin
        hold_r.symbol      <= new_sym;
        hold_r.tree_error  <= new_err;
        hold_r.last_symbol <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && push_req) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && push_req) begin
      out_res_r <= push_res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.symbol      = out_res_r.symbol;
  assign out_chan.last_symbol = out_res_r.last_symbol;
  assign out_chan.tree_error  = out_res_r.tree_error;

  always_ff @(posedge clk) begin
    if (advance && leaf_we) begin
      leaf_mem[leaf_waddr] <= leaf_wdata;
    end
    if (advance && a_we) begin
      a_mem[ab_waddr] <= ab_wdata;
    end
    if (advance && b_we) begin
      b_mem[ab_waddr] <= ab_wdata;
    end
    if (advance && rd_en) begin
      {rd_leaf_r, rd_sym_r} <= leaf_mem[rd_addr];
      rd_a_r                <= a_mem[rd_addr];
      rd_b_r                <= b_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stk_we) begin
      stk_mem[stack_top_r[htw_pkg::STACK_IDX_W-1:0]] <= nfn_r[IW-1:0];
    end
    if (advance && stk_re) begin
      stk_q_r <= stk_mem[stk_raddr];
    end
  end

`ifndef SYNTHESIS
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stack_top_r <= htw_pkg::STACK_LIMIT)
    else $error("pending stack grew past its capacity");

  a_node_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nfn_r <= htw_pkg::NODE_LIMIT)
    else $error("node allocation ran past the node table");

  a_pend_decode: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (phase_r == PH_DECODE && !root_leaf_r))
    else $error("tree read outstanding outside the walk");

  a_header_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_HEADER) |-> (sym_cnt_r == '0))
    else $error("symbol bit count left over after the header");

  a_block_end: assert property (@(posedge clk) disable iff (!rst_n)
    (head_pop && head.final_byte) |=>
      (phase_r == PH_HEADER && nfn_r == '0 && stack_top_r == '0 && !hold_valid_r))
    else $error("run state not cleared after the final byte");
`endif

endmodule
